// File: rtl/core/servo_pulse_slot_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// servo pulse slot sequencer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_SLOT_SEQUENCER_TOP_DEFINES_SVH
`define SERVO_PULSE_SLOT_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// item types, op codes and angle conversion for the servo slot sequencer
// ----------------------------------------------------------------------------
package sps_pkg;

    typedef enum logic [0:0] {
        OP_TICK      = 1'b0,
        OP_SET_ANGLE = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] channel;
        logic [7:0] angle;
    } t_in;

    typedef struct packed {
        logic [7:0] compare_value;
        logic [2:0] active_channel;
        logic [7:0] pin_levels;
    } t_out;

    localparam logic [7:0] MAX_ANGLE = 8'd180;

    // ticks = floor((angle*52 + 2750) / 100); the /100 is a multiply by
    // 5243 / 2^19, exact for every sum up to 180 degrees
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned ANGLE_SHIFT = 19;
    localparam int unsigned ANGLE_MULT  = 52 * RECIP_100;
    localparam int unsigned ANGLE_BIAS  = 2750 * RECIP_100;

    function automatic logic [7:0] angle_to_ticks(input logic [7:0] angle);
        logic [27:0] prod;
        prod = 28'(angle) * 28'(ANGLE_MULT) + 28'(ANGLE_BIAS);
        return prod[ANGLE_SHIFT+7:ANGLE_SHIFT];
    endfunction

endpackage

// File: rtl/core/servo_pulse_slot_sequencer_top.sv
// ----------------------------------------------------------------------------
// servo_pulse_slot_sequencer_top
// time-sliced pulse sequencer driving several servo pins from one timer
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall / i_in) takes one item per cycle while o_in_stall is low.
//   a tick item is one compare-match event of the shared timer; a set-angle
//   item stores a new pulse width for one channel and gives no result.
//   output channel (o_out_valid / i_out_stall / o_out) returns, for each
//   tick item, the next compare interval, the current slot and the pins.
// result: each tick result is registered, into the skid entry if the output is stalled.
// throughput: one item per cycle while the output side keeps up; the slot
//   advance, width lookup and pin update of the phase machine are all
//   combinational, so nothing there limits it.
// stall: the result register is backed by one skid entry; o_in_stall rises
//   only when both are full, and stays registered (no combinational path
//   from i_out_stall to o_in_stall).
// reset: synchronous, active low. every channel is idle (width equal to
//   the slot length), slot 0 is current, high phase, all pins low. no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module servo_pulse_slot_sequencer_top #(
    parameter int NUM_CHANNELS = 8,
    parameter int SLOT_TICKS   = 155
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sps_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sps_pkg::t_out o_out
);
    import sps_pkg::*;

    localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHAN_EXT_W = SLOT_W + 3;
    localparam int PIN_EXT_W  = NUM_CHANNELS + 8;
    localparam logic [7:0] SLOT_LEN = 8'(SLOT_TICKS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_CHANNELS - 1);

    // channel state
    logic [7:0]              r_width [NUM_CHANNELS];
    logic [7:0]              r_cur_width;   // copy of r_width[r_slot]
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_low;
    logic [NUM_CHANNELS-1:0] r_pins;

    logic [7:0]              n_cur_width;
    logic [SLOT_W-1:0]       n_slot;
    logic                    n_low;
    logic [NUM_CHANNELS-1:0] n_pins;

    // output register and skid entry
    logic r_out_valid, r_skid_valid;
    t_out r_out, r_skid;

    logic                    accept, res_valid, out_fire;
    logic                    set_ok;
    logic [CHAN_EXT_W-1:0]   chan_ext;
    logic [SLOT_W-1:0]       set_idx;
    logic [7:0]              set_ticks;
    logic [SLOT_W-1:0]       nxt_slot;
    logic [7:0]              nxt_width;
    logic                    cur_idle, nxt_idle, advance;
    logic [7:0]              cmp;
    logic [CHAN_EXT_W-1:0]   slot_ext;
    logic [PIN_EXT_W-1:0]    pins_ext;
    t_out                    res;

    assign accept    = i_in_valid && !r_skid_valid;
    assign res_valid = accept && (i_in.op == OP_TICK);
    assign out_fire  = r_out_valid && !i_out_stall;

    // set-angle decode: only in-range channels and angles are stored
    assign chan_ext  = CHAN_EXT_W'(i_in.channel);
    assign set_idx   = chan_ext[SLOT_W-1:0];
    assign set_ticks = angle_to_ticks(i_in.angle);
    assign set_ok    = accept && (i_in.op == OP_SET_ANGLE) && (i_in.angle <= MAX_ANGLE)
                       && (chan_ext < CHAN_EXT_W'(NUM_CHANNELS));

    // slot walk: idle slot or end of low phase both move to the next slot
    assign nxt_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign nxt_width = r_width[nxt_slot];
    assign cur_idle  = (r_cur_width == SLOT_LEN);
    assign nxt_idle  = (nxt_width == SLOT_LEN);
    assign advance   = r_low || cur_idle;

    always_comb begin
        n_slot      = r_slot;
        n_low       = r_low;
        n_pins      = r_pins;
        n_cur_width = r_cur_width;
        cmp         = nxt_width;
        if (advance) begin
            n_slot      = nxt_slot;
            n_low       = 1'b0;
            n_cur_width = nxt_width;
            cmp         = nxt_width;
            if (!nxt_idle) begin
                n_pins = r_pins | (NUM_CHANNELS'(1) << nxt_slot);
            end
        end else begin
            // end of high phase: rest of the slot with the pin low
            n_low  = 1'b1;
            cmp    = SLOT_LEN - r_cur_width;
            n_pins = r_pins & ~(NUM_CHANNELS'(1) << r_slot);
        end
    end

    assign slot_ext = CHAN_EXT_W'(n_slot);
    assign pins_ext = PIN_EXT_W'(n_pins);

    always_comb begin
        res.compare_value  = cmp;
        res.active_channel = slot_ext[2:0];
        res.pin_levels     = pins_ext[7:0];
    end

    // width table, reset to idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_width[i] <= SLOT_LEN;
            end
        end else if (set_ok) begin
            r_width[set_idx] <= set_ticks;
        end
    end

    // phase machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_low       <= 1'b0;
            r_pins      <= '0;
            r_cur_width <= SLOT_LEN;
        end else if (res_valid) begin
            r_slot      <= n_slot;
            r_low       <= n_low;
            r_pins      <= n_pins;
            r_cur_width <= n_cur_width;
        end else if (set_ok && (set_idx == r_slot)) begin
            r_cur_width <= set_ticks;
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// port-level checks for the servo slot sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "servo_pulse_slot_sequencer_top_defines.svh"

module sps_checker #(
    parameter int SLOT_TICKS = 155
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input sps_pkg::t_out o_out
);

    // a stalled item holds
    `SPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled output item changed")

    // input side only backs up once the result register is full
    `SPS_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid, "input stalled with empty output")

    // interval never zero and never beyond a slot
    `SPS_ASSERT_NOW(a_cmp_range, i_clk, i_rst_n, o_out_valid, (o_out.compare_value != 8'd0) && (o_out.compare_value <= 8'(SLOT_TICKS)), "compare interval out of range")

    // at most one pin high, and only that of the current slot
    `SPS_ASSERT_NOW(a_one_pin, i_clk, i_rst_n, o_out_valid, $onehot0(o_out.pin_levels) && ((o_out.pin_levels == 8'd0) || o_out.pin_levels[o_out.active_channel]), "pin levels disagree with slot")

endmodule

bind servo_pulse_slot_sequencer_top sps_checker #(.SLOT_TICKS(SLOT_TICKS)) u_sps_checker (.*);

// File: verif/tb_servo_pulse_slot_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_pulse_slot_sequencer_top
// self-checking bench for the servo pulse slot sequencer: a cycle-free
// model of the slot and phase machine predicts every compare result, while
// both channels idle at random and the output is held off to fill the block
// ----------------------------------------------------------------------------
module tb_servo_pulse_slot_sequencer_top;

    import sps_pkg::*;

    // block geometry and angle conversion constants
    localparam int CHANNELS     = 8;
    localparam int SLOT_LEN     = 155;
    localparam int DEG_GAIN     = 52;
    localparam int DEG_OFFSET   = 2750;
    localparam int DEG_SCALE    = 100;
    localparam int MAX_GAP      = 17;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_GUARD  = 5000;
    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int CHUNK_ITEMS  = 40;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  o_in_stall;
    t_in   in_data;
    logic  o_out_valid;
    logic  out_stall;
    t_out  o_out;

    // shared control between the test tasks and the receiver process
    bit    tx_idle_on;
    bit    rx_idle_on;
    int    rx_hold_cycles;
    int    error_count;

    // model state of the sequencer
    logic [7:0] model_width [CHANNELS];
    logic [2:0] model_slot;
    bit         model_low;
    logic [7:0] model_pins;

    // compare results still owed by the block, oldest first
    t_out  expected_pulses [$];

    servo_pulse_slot_sequencer_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // degrees to pulse ticks, exact integer division
    function automatic logic [7:0] ticks_for_angle(input logic [7:0] angle);
        int unsigned sum;
        sum = int'(angle) * DEG_GAIN + DEG_OFFSET;
        return 8'(sum / DEG_SCALE);
    endfunction

    function automatic bit slot_is_idle(input logic [2:0] slot);
        return model_width[slot] == 8'(SLOT_LEN);
    endfunction

    // next slot becomes current and starts its high phase
    function automatic logic [7:0] open_next_slot();
        model_slot = (int'(model_slot) == CHANNELS - 1) ? 3'd0 : model_slot + 3'd1;
        model_low  = 1'b0;
        if (!slot_is_idle(model_slot)) begin
            model_pins[model_slot] = 1'b1;
        end
        return model_width[model_slot];
    endfunction

    // apply one accepted item to the model; tick items owe one result
    task automatic advance_sequencer(input t_in item);
        t_out pulse;
        logic [7:0] interval;
        if (item.op == OP_SET_ANGLE) begin
            // out-of-range angles leave everything untouched
            if (item.angle <= MAX_ANGLE && int'(item.channel) < CHANNELS) begin
                model_width[item.channel] = ticks_for_angle(item.angle);
            end
        end else begin
            if (!model_low) begin
                if (slot_is_idle(model_slot)) begin
                    // idle slot passes in one interval
                    interval = open_next_slot();
                end else begin
                    // end of high pulse, rest of slot is low
                    interval = 8'(SLOT_LEN) - model_width[model_slot];
                    model_low = 1'b1;
                    model_pins[model_slot] = 1'b0;
                end
            end else begin
                interval = open_next_slot();
            end
            pulse.compare_value  = interval;
            pulse.active_channel = model_slot;
            pulse.pin_levels     = model_pins;
            expected_pulses.push_back(pulse);
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic check_pulse(input t_out got);
        t_out want;
        if (expected_pulses.size() == 0) begin
            $display("%0t: unexpected result cmp=%0d chan=%0d pins=%b",
                     $time, got.compare_value, got.active_channel, got.pin_levels);
            error_count++;
        end else begin
            want = expected_pulses.pop_front();
            if (got.compare_value !== want.compare_value) begin
                $display("%0t: compare_value expected %0d actual %0d",
                         $time, want.compare_value, got.compare_value);
                error_count++;
            end
            if (got.active_channel !== want.active_channel) begin
                $display("%0t: active_channel expected %0d actual %0d",
                         $time, want.active_channel, got.active_channel);
                error_count++;
            end
            if (got.pin_levels !== want.pin_levels) begin
                $display("%0t: pin_levels expected %b actual %b",
                         $time, want.pin_levels, got.pin_levels);
                error_count++;
            end
        end
    endtask

    // both handshakes watched at the edge; results first so the front of the
    // queue can never be an item accepted at this same edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                check_pulse(o_out);
            end
            if (in_valid && !o_in_stall) begin
                advance_sequencer(in_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall before each result, plus a long hold on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int gap;
        int held;
        out_stall = 1'b0;
        forever begin
            if (rx_hold_cycles > 0) begin
                held = rx_hold_cycles;
                rx_hold_cycles = 0;
                out_stall <= 1'b1;
                repeat (held) @(posedge clk);
            end
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(o_out_valid && !out_stall)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one item after a random gap and hold it until taken
    task automatic send_item(input t_in item);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!(in_valid && !o_in_stall)) @(posedge clk);
    endtask

    // tick fields other than op are don't-care, so fill them with noise
    task automatic send_tick();
        t_in item;
        item.op      = OP_TICK;
        item.channel = 3'($urandom_range(0, 7));
        item.angle   = 8'($urandom_range(0, 255));
        send_item(item);
    endtask

    task automatic send_angle(input int chan, input int angle);
        t_in item;
        item.op      = OP_SET_ANGLE;
        item.channel = 3'(chan);
        item.angle   = 8'(angle);
        send_item(item);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset state, conversion extremes, ignored angles and each phase path
    task automatic test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // all channels idle: slot steps on, full-slot intervals, pins low
        send_tick();
        send_tick();
        send_angle(0, 0);
        send_angle(7, 180);
        send_angle(3, 181);
        send_angle(5, 255);
        send_angle(1, 90);
        // walk idle slots up to channel 7, through its pulse, wrap to 0
        repeat (7) send_tick();
        // change the width of the channel in its high phase
        send_angle(0, 45);
        repeat (3) send_tick();
        // retarget the current channel while it sits in its low phase
        send_angle(1, 1);
        repeat (4) send_tick();
    endtask

    // mostly well-formed tick streams with angle updates mixed in
    task automatic test_random_traffic();
        int counted;
        int pick;
        int angle;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            // some chunks run with no idling on either side
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat (CHUNK_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    send_tick();
                    counted++;
                end else begin
                    if (pick < 90) begin
                        angle = $urandom_range(0, 180);
                    end else begin
                        angle = $urandom_range(0, 255);
                    end
                    send_angle($urandom_range(0, 7), angle);
                    if (angle <= int'(MAX_ANGLE)) begin
                        counted++;
                    end
                end
            end
        end
    endtask

    // receiver holds off while ticks keep coming, so the input backs up
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 80;
        repeat (30) send_tick();
        rx_idle_on = 1'b1;
    endtask

    // wait for every owed result, then let any stragglers settle
    task automatic drain_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_pulses.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (expected_pulses.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_pulses.size());
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = 0;
        error_count    = 0;
        // model reset: every channel idle, slot 0, high phase, pins low
        for (int i = 0; i < CHANNELS; i++) begin
            model_width[i] = 8'(SLOT_LEN);
        end
        model_slot = 3'd0;
        model_low  = 1'b0;
        model_pins = 8'd0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_backpressure();
        test_random_traffic();
        test_output_backpressure();
        drain_results();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
